### hw/rtl/nearest_palette_color_search_assert.svh
// Assertion macros used by the palette search top level.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define NPCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define NPCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/npcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest palette colour search: shared package
// Sizes, request codes and the payload and scan-token structures.
// ----------------------------------------------------------------------------
package npcs_pkg;

  // Palette geometry.
  localparam int MAX_ENTRIES = 256;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Field widths fixed by the interface.
  localparam int CHAN_W    = 8;
  localparam int DIST_W    = 10;
  localparam int OUT_IDX_W = 8;

  // Reset value of the distance limit.
  localparam logic [DIST_W-1:0] MAX_DIST_RESET = 10'd100;

  // Request type codes.
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // Request payload.
  typedef struct packed {
    logic [1:0]        req_type;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } npcs_req_t;

  // Response payload.
  typedef struct packed {
    logic                 match_found;
    logic [OUT_IDX_W-1:0] match_index;
    logic [DIST_W-1:0]    match_distance;
    logic                 table_full;
  } npcs_rsp_t;

  // Query token handed from cell to cell along the chain.
  typedef struct packed {
    logic              live;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [DIST_W-1:0] best;
    logic              found;
    logic [IDX_W-1:0]  best_idx;
  } npcs_tok_t;

endpackage

### hw/rtl/npcs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette search cell
// Holds one palette entry, compares it with the passing query token and
// hands the updated token, registered, to the next cell.
// ----------------------------------------------------------------------------
module npcs_cell
  import npcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IDX_W-1:0]      index,
  input  logic                  active,
  input  logic                  wr_en,
  input  logic [3*CHAN_W-1:0]   wr_color,
  input  npcs_tok_t             tok_in,
  output npcs_tok_t             tok_out
);

  logic [3*CHAN_W-1:0] entry;
  logic [DIST_W-1:0]   distance;
  logic                hit;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // Entry storage, written once per add aimed at this cell.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_color;
    end
  end

  // Manhattan distance between the token colour and the stored entry.
  always_comb begin
    distance = DIST_W'(abs_diff(tok_in.red,   entry[3*CHAN_W-1:2*CHAN_W]))
             + DIST_W'(abs_diff(tok_in.green, entry[2*CHAN_W-1:CHAN_W]))
             + DIST_W'(abs_diff(tok_in.blue,  entry[CHAN_W-1:0]));
    hit      = tok_in.live && active && (distance < tok_in.best);
  end

  // The live bit is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.live <= 1'b0;
    end else begin
      tok_out.live <= tok_in.live;
    end
  end

  // Token payload: keep the first strictly closer entry.
  always_ff @(posedge clk) begin
    tok_out.red      <= tok_in.red;
    tok_out.green    <= tok_in.green;
    tok_out.blue     <= tok_in.blue;
    tok_out.best     <= hit ? distance : tok_in.best;
    tok_out.found    <= tok_in.found | hit;
    tok_out.best_idx <= hit ? index : tok_in.best_idx;
  end

endmodule

### hw/rtl/nearest_palette_color_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest palette colour search
// Palette of RGB entries held in a row of cells; a query token walks the row
// and picks the first entry with the smallest Manhattan distance under the limit.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req/req_valid and are taken when req_stall is low.
//   Each request gives exactly one response on rsp/rsp_valid, which is held
//   steady while rsp_stall is high.
//   Add, clear and unused request types answer in the cycle after their
//   transfer. A query walks the whole row of MAX_ENTRIES cells, one cell
//   per cycle, then passes the hold register and the output register.
//   The block handles one request at a time; the length of the cell row sets
//   the query time. A new request is taken while a response waits in the
//   output register only if that register is being emptied in the same cycle.
//   cfg_data sets the distance limit and is always ready; write it only when
//   the block is idle.
//   Reset empties the palette (entry count to zero), sets the limit to 100
//   and drops any query in flight; no clearing pass is needed.
//   While the receiver stalls, the result stays in the output register and
//   req_stall stays high.
// ----------------------------------------------------------------------------
`include "nearest_palette_color_search_assert.svh"

module nearest_palette_color_search
  import npcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  npcs_req_t         req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output npcs_rsp_t         rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DIST_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } npcs_state_t;

  npcs_state_t       state;
  npcs_state_t       state_next;
  logic [CNT_W-1:0]  entry_count;
  logic [DIST_W-1:0] max_distance;
  npcs_rsp_t         hold;
  npcs_tok_t         tok [MAX_ENTRIES+1];

  logic      out_free;
  logic      accept;
  logic      is_add;
  logic      is_clear;
  logic      is_query;
  logic      full;
  logic      add_fire;
  npcs_rsp_t direct_rsp;
  npcs_rsp_t tail_rsp;

  // Handshake decode.
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !((state == ST_IDLE) && out_free);
  assign accept    = req_valid && !req_stall;
  assign cfg_ready = 1'b1;

  assign is_add   = (req.req_type == REQ_ADD);
  assign is_clear = (req.req_type == REQ_CLEAR);
  assign is_query = (req.req_type == REQ_QUERY);
  assign full     = (entry_count == CNT_W'(MAX_ENTRIES));
  assign add_fire = accept && is_add && !full;

  // Distance limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= MAX_DIST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_distance <= cfg_data;
    end
  end

  // Entry count: append on add, empty on clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (add_fire) begin
      entry_count <= entry_count + CNT_W'(1);
    end else if (accept && is_clear) begin
      entry_count <= '0;
    end
  end

  // Query token entering the first cell.
  always_comb begin
    tok[0].live     = accept && is_query;
    tok[0].red      = req.red_in;
    tok[0].green    = req.green_in;
    tok[0].blue     = req.blue_in;
    tok[0].best     = max_distance;
    tok[0].found    = 1'b0;
    tok[0].best_idx = '0;
  end

  // Row of cells, one palette entry each.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    npcs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .index    (IDX_W'(i)),
      .active   (CNT_W'(i) < entry_count),
      .wr_en    (add_fire && (entry_count == CNT_W'(i))),
      .wr_color ({req.red_in, req.green_in, req.blue_in}),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  // Immediate response for add, clear and unused types.
  always_comb begin
    direct_rsp = '0;
    if (is_add) begin
      if (full) begin
        direct_rsp.table_full = 1'b1;
      end else begin
        direct_rsp.match_index = OUT_IDX_W'(entry_count);
      end
    end
  end

  // Query response from the token leaving the last cell.
  always_comb begin
    tail_rsp                = '0;
    tail_rsp.match_found    = tok[MAX_ENTRIES].found;
    tail_rsp.match_index    = OUT_IDX_W'(tok[MAX_ENTRIES].best_idx);
    tail_rsp.match_distance = tok[MAX_ENTRIES].found ? tok[MAX_ENTRIES].best : '0;
  end

  // Sequencer: idle, walking the row, holding a finished query result.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_query) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok[MAX_ENTRIES].live) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Query result holding register.
  always_ff @(posedge clk) begin
    if ((state == ST_SCAN) && tok[MAX_ENTRIES].live) begin
      hold <= tail_rsp;
    end
  end

  // Output register valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((accept && !is_query) || ((state == ST_HOLD) && out_free)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept && !is_query) begin
      rsp <= direct_rsp;
    end else if ((state == ST_HOLD) && out_free) begin
      rsp <= hold;
    end
  end

  // Checks on the sequencer and the cell row.
  `NPCS_ASSERT_NOW(a_count_range, clk, rst, 1'b1,
                   entry_count <= CNT_W'(MAX_ENTRIES),
                   "entry count beyond palette size")
  `NPCS_ASSERT_NOW(a_tail_in_scan, clk, rst, tok[MAX_ENTRIES].live,
                   state == ST_SCAN,
                   "query token left the row outside a scan")
  `NPCS_ASSERT_NEXT(a_query_starts_scan, clk, rst, accept && is_query,
                    state == ST_SCAN && !rsp_valid || state == ST_SCAN,
                    "accepted query did not start a scan")
  `NPCS_ASSERT_NOW(a_busy_stalls, clk, rst, state != ST_IDLE, req_stall,
                   "request transfer while a query is in flight")

endmodule
